// ===== rtl/ethx_pkg.sv =====
package ethx_pkg;

    localparam int MAX_FRAME_BYTES = 2048;
    // position counter saturates at MAX_FRAME_BYTES, so it must hold that value
    localparam int POS_W = $clog2(MAX_FRAME_BYTES + 1);
    // header end can reach 14 + 60 + 60 = 134
    localparam int OFS_W = (POS_W > 8) ? POS_W : 8;

    localparam int LIMIT_W = 7;
    localparam int INDEX_W = 6;

    localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
    localparam logic [7:0]  PROTO_TCP      = 8'd6;
    localparam logic [3:0]  MIN_HDR_WORDS  = 4'd5;
    localparam logic [7:0]  OFFSET_MASK    = 8'hf0;
    localparam logic [LIMIT_W-1:0] PAYLOAD_CAP   = 7'd64;
    localparam logic [LIMIT_W-1:0] LIMIT_DEFAULT = 7'd20;

    localparam logic KIND_SUMMARY = 1'b0;
    localparam logic KIND_PAYLOAD = 1'b1;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       frame_end;
    } t_in_item;

    typedef struct packed {
        logic               kind;
        logic [47:0]        source_mac;
        logic [47:0]        dest_mac;
        logic [31:0]        source_ip;
        logic [31:0]        dest_ip;
        logic [15:0]        source_port;
        logic [15:0]        dest_port;
        logic [7:0]         payload_value;
        logic [INDEX_W-1:0] payload_index;
        logic               last_of_frame;
    } t_out_item;

endpackage

// ===== rtl/ethx_parser.sv =====
module ethx_parser
    import ethx_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  t_in_item           i_item,
    input  logic [LIMIT_W-1:0] i_limit,
    output t_out_item          o_res,
    output logic               o_res_valid
);

    logic [POS_W-1:0]   r_pos, n_pos;
    logic [3:0]         r_ip_words, n_ip_words;
    logic [3:0]         r_tcp_words, n_tcp_words;
    logic [15:0]        r_ether_kind, n_ether_kind;
    logic [47:0]        r_src_mac, n_src_mac;
    logic [47:0]        r_dst_mac, n_dst_mac;
    logic [31:0]        r_src_ip, n_src_ip;
    logic [31:0]        r_dst_ip, n_dst_ip;
    logic [15:0]        r_src_port, n_src_port;
    logic [15:0]        r_dst_port, n_dst_port;
    logic [LIMIT_W-1:0] r_pay_count, n_pay_count;
    logic               r_rejected, n_rejected;

    logic [OFS_W-1:0]   pos_x;
    logic [OFS_W-1:0]   tcp_start;
    logic [OFS_W-1:0]   hdr_end;
    logic [OFS_W-1:0]   tcp_off;
    logic [LIMIT_W-1:0] lim;
    logic [7:0]         b;
    logic [3:0]         tcp_field;

    always_comb begin
        b         = i_item.data_byte;
        pos_x     = OFS_W'(r_pos);
        tcp_start = OFS_W'(14) + {{(OFS_W-6){1'b0}}, r_ip_words, 2'b00};
        hdr_end   = tcp_start + {{(OFS_W-6){1'b0}}, r_tcp_words, 2'b00};
        tcp_off   = pos_x - tcp_start;
        lim       = (i_limit > PAYLOAD_CAP) ? PAYLOAD_CAP : i_limit;
        tcp_field = 4'((b & OFFSET_MASK) >> 4);

        n_pos        = r_pos;
        n_ip_words   = r_ip_words;
        n_tcp_words  = r_tcp_words;
        n_ether_kind = r_ether_kind;
        n_src_mac    = r_src_mac;
        n_dst_mac    = r_dst_mac;
        n_src_ip     = r_src_ip;
        n_dst_ip     = r_dst_ip;
        n_src_port   = r_src_port;
        n_dst_port   = r_dst_port;
        n_pay_count  = r_pay_count;
        n_rejected   = r_rejected;

        o_res       = '0;
        o_res_valid = 1'b0;

        if (!r_rejected) begin
            if (r_tcp_words != 4'd0 && pos_x >= hdr_end) begin
                if (r_pay_count < lim) begin
                    o_res_valid          = 1'b1;
                    o_res.kind           = KIND_PAYLOAD;
                    o_res.payload_value  = b;
                    o_res.payload_index  = r_pay_count[INDEX_W-1:0];
                    o_res.last_of_frame  = i_item.frame_end ||
                                           (r_pay_count + LIMIT_W'(1) == lim);
                    n_pay_count          = r_pay_count + LIMIT_W'(1);
                end
            end else if (r_pos >= POS_W'(MAX_FRAME_BYTES)) begin
                n_rejected = 1'b1;
            end else if (pos_x < OFS_W'(6)) begin
                n_dst_mac = {r_dst_mac[39:0], b};
            end else if (pos_x < OFS_W'(12)) begin
                n_src_mac = {r_src_mac[39:0], b};
            end else if (pos_x == OFS_W'(12)) begin
                n_ether_kind = {b, 8'h00};
            end else if (pos_x == OFS_W'(13)) begin
                n_ether_kind = {r_ether_kind[15:8], b};
                if ({r_ether_kind[15:8], b} != ETHERTYPE_IPV4) begin
                    n_rejected = 1'b1;
                end
            end else if (pos_x == OFS_W'(14)) begin
                n_ip_words = b[3:0];
                if (b[3:0] < MIN_HDR_WORDS) begin
                    n_rejected = 1'b1;
                end
            end else if (pos_x == OFS_W'(23)) begin
                if (b != PROTO_TCP) begin
                    n_rejected = 1'b1;
                end
            end else if (pos_x >= OFS_W'(26) && pos_x < OFS_W'(30)) begin
                n_src_ip = {r_src_ip[23:0], b};
            end else if (pos_x >= OFS_W'(30) && pos_x < OFS_W'(34)) begin
                n_dst_ip = {r_dst_ip[23:0], b};
            end else if (pos_x >= tcp_start) begin
                if (tcp_off < OFS_W'(2)) begin
                    n_src_port = {r_src_port[7:0], b};
                end else if (tcp_off < OFS_W'(4)) begin
                    n_dst_port = {r_dst_port[7:0], b};
                end else if (tcp_off == OFS_W'(12)) begin
                    if (tcp_field < MIN_HDR_WORDS) begin
                        n_rejected = 1'b1;
                    end else begin
                        n_tcp_words = tcp_field;
                    end
                end
                // data offset byte can never be the last header byte,
                // so the registered offset is enough here
                if (r_tcp_words != 4'd0 && pos_x + OFS_W'(1) == hdr_end) begin
                    o_res_valid         = 1'b1;
                    o_res.kind          = KIND_SUMMARY;
                    o_res.source_mac    = n_src_mac;
                    o_res.dest_mac      = n_dst_mac;
                    o_res.source_ip     = n_src_ip;
                    o_res.dest_ip       = n_dst_ip;
                    o_res.source_port   = n_src_port;
                    o_res.dest_port     = n_dst_port;
                    o_res.last_of_frame = i_item.frame_end || (lim == '0);
                end
            end
        end

        if (i_item.frame_end) begin
            n_pos        = '0;
            n_ip_words   = '0;
            n_tcp_words  = '0;
            n_ether_kind = '0;
            n_pay_count  = '0;
            n_rejected   = 1'b0;
        end else if (r_pos < POS_W'(MAX_FRAME_BYTES)) begin
            n_pos = r_pos + POS_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos        <= '0;
            r_ip_words   <= '0;
            r_tcp_words  <= '0;
            r_ether_kind <= '0;
            r_pay_count  <= '0;
            r_rejected   <= 1'b0;
        end else if (i_accept) begin
            r_pos        <= n_pos;
            r_ip_words   <= n_ip_words;
            r_tcp_words  <= n_tcp_words;
            r_ether_kind <= n_ether_kind;
            r_pay_count  <= n_pay_count;
            r_rejected   <= n_rejected;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_src_mac  <= n_src_mac;
            r_dst_mac  <= n_dst_mac;
            r_src_ip   <= n_src_ip;
            r_dst_ip   <= n_dst_ip;
            r_src_port <= n_src_port;
            r_dst_port <= n_dst_port;
        end
    end

    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pay_count <= PAYLOAD_CAP)
        else $error("payload count beyond cap");

    a_tcp_words_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tcp_words == 4'd0 || r_tcp_words >= MIN_HDR_WORDS)
        else $error("tcp data offset stored below minimum");

    a_pos_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= POS_W'(MAX_FRAME_BYTES))
        else $error("byte position past saturation");

endmodule

// ===== rtl/eth_ipv4_tcp_header_extractor_top.sv =====
// Ethernet/IPv4/TCP header extractor. Frame bytes enter one per request in
// wire order, frame_end set on the last byte. Frames with EtherType 0x0800
// and IP protocol 6 give one summary result (MACs, IPs, ports) on the last
// TCP header byte, then up to payload_limit payload bytes (capped at 64,
// reset 20), with last_of_frame on the final result of the frame. Short or
// malformed frames give nothing. Each byte is parsed as it is accepted and
// its result lands in a single output register, so the block takes a byte
// every cycle while the output side keeps up. The limit register may be
// written any time the block is idle.
module eth_ipv4_tcp_header_extractor_top
    import ethx_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  t_in_item           i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output t_out_item          o_out_data,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [LIMIT_W-1:0] i_cfg_data
);

    logic [LIMIT_W-1:0] r_limit;
    logic               r_out_valid, n_out_valid;
    t_out_item          r_out_data;
    logic               in_accept;
    t_out_item          res;
    logic               res_valid;

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign in_accept   = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    ethx_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (in_accept),
        .i_item      (i_in_data),
        .i_limit     (r_limit),
        .o_res       (res),
        .o_res_valid (res_valid)
    );

    always_comb begin
        if (in_accept) begin
            n_out_valid = res_valid;
        end else begin
            n_out_valid = r_out_valid && !i_out_ready;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_limit     <= LIMIT_DEFAULT;
        end else begin
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                r_limit <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept && res_valid) begin
            r_out_data <= res;
        end
    end

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty output register");

    a_payload_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.kind == KIND_PAYLOAD |->
        o_out_data.source_mac == '0 && o_out_data.dest_ip == '0 &&
        o_out_data.source_port == '0)
        else $error("payload result carries header fields");

    a_summary_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.kind == KIND_SUMMARY |->
        o_out_data.payload_value == '0 && o_out_data.payload_index == '0)
        else $error("summary result carries payload fields");

    a_result_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && !i_in_valid |=> !o_out_valid)
        else $error("result repeated after being taken");

endmodule
